### sv/csl_pkg.sv
// Shared widths and constants for the copy scale line count block.
package csl_pkg;

   // Field widths of the item channels.
   localparam int HEIGHT_W = 10;
   localparam int SCALE_W  = 9;
   localparam int LINE_W   = 11;

   // Working widths: the scaled height and the odd part of a scale below 256.
   localparam int DVD_W = HEIGHT_W + 8;
   localparam int ODD_W = SCALE_W - 1;

   // Scale unit, half unit and the line count ceiling.
   localparam logic [SCALE_W-1:0] SCALE_UNIT = 9'h100;
   localparam logic [SCALE_W-1:0] SCALE_HALF = 9'h080;
   localparam logic [LINE_W-1:0]  LINE_CLAMP = 11'h400;

endpackage

### sv/csl_serdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module csl_serdiv #(
   parameter int DVD_W = csl_pkg::DVD_W,
   parameter int DVS_W = csl_pkg::SCALE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);
   import csl_pkg::*;

   localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   part;
   logic [DVS_W+1:0] diff;
   logic             qbit;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      part = {rem_ff, dvd_ff[DVD_W-1]};
      diff = {1'b0, part} - {2'b00, dvs_ff};
      qbit = ~diff[DVS_W+1];
   end

   // Sequencing: the dividend register fills with quotient bits from the right.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W - 1);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], qbit};
         rem_in = qbit ? diff[DVS_W-1:0] : part[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   // The last step completes at the edge where done is high.
   assign done      = busy_ff && (cnt_ff == '0);
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

### sv/csl_oddpart.sv
// Serial odd part extraction: shifts the scale right one bit per cycle.
module csl_oddpart (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [csl_pkg::ODD_W-1:0] value,
   output logic                      done,
   output logic [csl_pkg::ODD_W-1:0] odd
);
   import csl_pkg::*;

   logic             busy_ff, busy_in;
   logic [ODD_W-1:0] val_ff, val_in;

   // Finished once the lowest bit is set; a zero value stops at once as well.
   assign done = busy_ff && (val_ff[0] || (val_ff == '0));
   assign odd  = val_ff;

   always_comb begin
      busy_in = busy_ff;
      val_in  = val_ff;
      if (start) begin
         busy_in = 1'b1;
         val_in  = value;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         val_in = val_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

### sv/copy_scale_line_count.sv
// Top level of the copy scale line count block.
// The block takes a source height and a vertical copy scale in 1/256 units and
// returns ((height-1)*256)/scale + 1 output lines, plus one when the scale lies
// strictly between 128 and 256 and its odd part divides the height, clamped at
// 1024. A zero height gives 1024 lines; a zero scale gives 0 lines with
// scale_error set. One item is worked on at a time. For a normal item the
// 18-bit quotient comes out of a bit-serial divider one bit per cycle, while
// the odd part search (up to 6 shifts) and the 10-bit remainder divider run
// alongside it when the scale lies in that range. Zero height and zero scale
// items skip the serial units. A new item is accepted while a finished result
// still waits in the output register.
module copy_scale_line_count (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [csl_pkg::HEIGHT_W-1:0] req_source_height,
   input  logic [csl_pkg::SCALE_W-1:0]  req_copy_scale,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [csl_pkg::LINE_W-1:0]   rsp_line_count,
   output logic                         rsp_scale_error
);
   import csl_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [HEIGHT_W-1:0] hgt_ff, hgt_in;
   logic                zero_h_ff, zero_h_in;
   logic                err_ff, err_in;
   logic                range_ff, range_in;
   logic                div_fin_ff, div_fin_in;
   logic                mod_fin_ff, mod_fin_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic                rsp_err_ff, rsp_err_in;

   logic                accept;
   logic                in_range;
   logic                special;
   logic                div_start;
   logic                odd_start;
   logic                div_done;
   logic                odd_done;
   logic                mod_done;
   logic [DVD_W-1:0]    dividend;
   logic [DVD_W-1:0]    quot;
   logic [ODD_W-1:0]    odd_val;
   logic [ODD_W-1:0]    mod_rem;
   logic                extra;
   logic [DVD_W:0]      sum;
   logic [LINE_W-1:0]   line_calc;
   logic                out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Scale strictly between the half unit and the unit.
   assign in_range = (req_copy_scale > SCALE_HALF) && (req_copy_scale < SCALE_UNIT);
   assign special  = (req_copy_scale == '0) || (req_source_height == '0);

   assign div_start = accept && !special;
   assign odd_start = div_start && in_range;
   assign dividend  = {req_source_height - 1'b1, 8'h00};

   // Scaled height divided by the scale.
   csl_serdiv #(
      .DVD_W(DVD_W),
      .DVS_W(SCALE_W)
   ) u_quot (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (req_copy_scale),
      .done      (div_done),
      .quotient  (quot),
      .remainder ()
   );

   // Odd part of the scale.
   csl_oddpart u_odd (
      .clock (clock),
      .reset (reset),
      .start (odd_start),
      .value (req_copy_scale[ODD_W-1:0]),
      .done  (odd_done),
      .odd   (odd_val)
   );

   // Height modulo the odd part, started once the odd part is known.
   csl_serdiv #(
      .DVD_W(HEIGHT_W),
      .DVS_W(ODD_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (odd_done),
      .dividend  (hgt_ff),
      .divisor   (odd_val),
      .done      (mod_done),
      .quotient  (),
      .remainder (mod_rem)
   );

   // Final count with the extra line and the clamp.
   always_comb begin
      extra = range_ff && (mod_rem == '0);
      sum   = {1'b0, quot} + (DVD_W + 1)'(1) + (DVD_W + 1)'(extra);
      if (zero_h_ff || (sum > (DVD_W + 1)'(LINE_CLAMP))) begin
         line_calc = LINE_CLAMP;
      end else begin
         line_calc = sum[LINE_W-1:0];
      end
   end

   // Item sequencing.
   always_comb begin
      state_in     = state_ff;
      hgt_in       = hgt_ff;
      zero_h_in    = zero_h_ff;
      err_in       = err_ff;
      range_in     = range_ff;
      div_fin_in   = div_fin_ff | div_done;
      mod_fin_in   = mod_fin_ff | mod_done;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      line_in      = line_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hgt_in     = req_source_height;
               zero_h_in  = (req_source_height == '0);
               err_in     = (req_copy_scale == '0);
               range_in   = in_range && !special;
               div_fin_in = special;
               mod_fin_in = special || !in_range;
               state_in   = special ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (div_fin_ff && mod_fin_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               line_in      = err_ff ? '0 : line_calc;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_fin_ff   <= 1'b0;
         mod_fin_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_fin_ff   <= div_fin_in;
         mod_fin_ff   <= mod_fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hgt_ff     <= hgt_in;
      zero_h_ff  <= zero_h_in;
      err_ff     <= err_in;
      range_ff   <= range_in;
      line_ff    <= line_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_count  = line_ff;
   assign rsp_scale_error = rsp_err_ff;

`ifndef NO_ASSERTIONS
   // An error result always carries a zero line count.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scale_error |-> (rsp_line_count == '0))
      else $error("scale error with nonzero line count");

   // The line count never exceeds the clamp.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_count <= LINE_CLAMP))
      else $error("line count above clamp");

   // A result is only formed once the quotient and remainder finish flags are both set.
   a_done_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (div_fin_ff && mod_fin_ff))
      else $error("result formed before division finished");

   // An accepted item leaves the idle state on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start");
`endif

endmodule

### sim/tb_copy_scale_line_count.sv
// Self-checking testbench for the copy scale line count block.
`timescale 1ns / 1ps

module tb_copy_scale_line_count;
   import csl_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_WAIT  = 40;
   localparam int REPORT_LIMIT = 10;

   // One expected line count, with the item that caused it for reporting.
   typedef struct packed {
      logic [HEIGHT_W-1:0] source_height;
      logic [SCALE_W-1:0]  copy_scale;
      logic [LINE_W-1:0]   line_count;
      logic                scale_error;
   } line_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [HEIGHT_W-1:0] req_source_height = '0;
   logic [SCALE_W-1:0]  req_copy_scale = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [LINE_W-1:0]   rsp_line_count;
   logic                rsp_scale_error;

   line_result_type expected_counts[$];
   int              fail_count = 0;
   int              cycle_count = 0;
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   int              stall_hold_left = 0;

   copy_scale_line_count i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_height(req_source_height),
      .req_copy_scale   (req_copy_scale),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_count   (rsp_line_count),
      .rsp_scale_error  (rsp_scale_error)
   );

   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d items outstanding",
                  cycle_count, expected_counts.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Output line count: 32-bit wrapped scaled height over the scale, plus one,
   // plus one more when a scale between half and full unit has an odd part
   // dividing the height, then clamped; a zero scale gives zero with an error.
   function automatic line_result_type predict_line_count(logic [HEIGHT_W-1:0] height,
                                                          logic [SCALE_W-1:0] scale);
      line_result_type    result;
      logic [31:0]        scaled;
      logic [31:0]        lines;
      logic [SCALE_W-1:0] odd_part;
      result.source_height = height;
      result.copy_scale    = scale;
      if (scale == '0) begin
         result.line_count  = '0;
         result.scale_error = 1'b1;
         return result;
      end
      scaled = (32'(height) - 32'd1) << 8;
      lines  = scaled / 32'(scale) + 32'd1;
      if (scale > SCALE_HALF && scale < SCALE_UNIT) begin
         odd_part = scale;
         while (odd_part[0] == 1'b0)
            odd_part = odd_part >> 1;
         if (32'(height) % 32'(odd_part) == 32'd0)
            lines = lines + 32'd1;
      end
      if (lines > 32'(LINE_CLAMP))
         lines = 32'(LINE_CLAMP);
      result.line_count  = lines[LINE_W-1:0];
      result.scale_error = 1'b0;
      return result;
   endfunction

   // Receiver: a long hold when one is requested, random stalls otherwise.
   always @(negedge clock) begin
      if (stall_hold_left > 0) begin
         rsp_stall <= 1'b1;
         stall_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Compare each accepted result with the oldest expected line count.
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("Unexpected result: line_count %0d scale_error %0b",
                        rsp_line_count, rsp_scale_error);
         end else begin
            want = expected_counts.pop_front();
            if (rsp_line_count !== want.line_count ||
                rsp_scale_error !== want.scale_error) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("Mismatch for height %0d scale %0d: expected %0d/%0b, got %0d/%0b",
                           want.source_height, want.copy_scale, want.line_count,
                           want.scale_error, rsp_line_count, rsp_scale_error);
            end
         end
      end
   end

   // Offer one item after random idle cycles and wait until it is accepted.
   task automatic send_item(input logic [HEIGHT_W-1:0] height,
                            input logic [SCALE_W-1:0] scale);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_source_height <= height;
      req_copy_scale    <= scale;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_counts.push_back(predict_line_count(height, scale));
   endtask

   // Random item, often a scale with an odd part that divides the height.
   task automatic send_random_item();
      logic [SCALE_W-1:0] scale;
      logic [SCALE_W-1:0] odd_part;
      int                 pick;
      int                 height;
      pick = $urandom_range(99);
      if (pick < 50) begin
         send_item(HEIGHT_W'($urandom_range(1023)), SCALE_W'($urandom_range(511)));
      end else if (pick < 80) begin
         scale    = SCALE_W'($urandom_range(SCALE_UNIT - 1, SCALE_HALF + 1));
         odd_part = scale;
         while (odd_part[0] == 1'b0)
            odd_part = odd_part >> 1;
         height = odd_part * $urandom_range(1023 / odd_part);
         send_item(HEIGHT_W'(height), scale);
      end else if (pick < 90) begin
         send_item(HEIGHT_W'($urandom_range(3)), SCALE_W'($urandom_range(511)));
      end else begin
         case ($urandom_range(4))
            0: scale = '0;
            1: scale = 9'd1;
            2: scale = SCALE_HALF;
            3: scale = SCALE_UNIT;
            default: scale = 9'd511;
         endcase
         send_item(HEIGHT_W'($urandom_range(1023)), scale);
      end
   endtask

   // Field extremes, zero height, zero scale and the extra line cases.
   task automatic test_corner_items();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_item(0, 0);
      send_item(0, 1);
      send_item(0, 255);
      send_item(0, 511);
      send_item(1, 0);
      send_item(1, 1);
      send_item(1023, 1);
      send_item(1023, 511);
      send_item(1023, 0);
      send_item(1023, 256);
      send_item(1023, 128);
      send_item(1, 511);
      send_item(2, 511);
      send_item(3, 192);
      send_item(4, 192);
      send_item(5, 160);
      send_item(258, 129);
      send_item(128, 128);
      send_item(510, 255);
      send_item(765, 255);
      send_item(1020, 255);
      send_item(512, 256);
      send_item(1023, 129);
      send_item(640, 200);
   endtask

   // Random items under the given idle and stall rates.
   task automatic test_random_items(input int count, input int idle_pct,
                                    input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count)
         send_random_item();
   endtask

   // Receiver holds off for a long stretch while items keep coming, so the
   // block fills up and stalls its input.
   task automatic test_output_hold();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      stall_hold_left    = 300;
      repeat (20)
         send_random_item();
   endtask

   // Sender pauses until every outstanding item has returned, then resumes.
   task automatic test_drain_pause();
      sender_idle_pct    = 17;
      receiver_stall_pct = 17;
      repeat (15)
         send_random_item();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (15)
         send_random_item();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_items();
      test_random_items(100, 0, 0);
      test_random_items(100, 60, 0);
      test_random_items(100, 0, 60);
      test_random_items(100, 17, 17);
      test_output_hold();
      test_drain_pause();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (fail_count == 0 && expected_counts.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
sv/csl_pkg.sv
sv/csl_serdiv.sv
sv/csl_oddpart.sv
sv/copy_scale_line_count.sv
sim/tb_copy_scale_line_count.sv
